>>> rtl/plc_pkg.sv
`default_nettype none

package plc_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int CLIP_WIDTH = 24;
   localparam int LEN_WIDTH = 27;

   localparam logic [CLIP_WIDTH-1:0] CLIP_RESET = 24'd16384;
   localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_BIT = 2;
   localparam logic REG_CLIP_LENGTH = 1'b0;

endpackage

`default_nettype wire

>>> rtl/plc_if.sv
`default_nettype none

interface plc_req_if #(
   parameter int COORD_WIDTH = plc_pkg::COORD_WIDTH_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] point_x;
   logic [COORD_WIDTH-1:0] point_y;
   logic                   first_vertex;
   logic                   last_vertex;

   modport source (output valid, point_x, point_y, first_vertex, last_vertex, input ready);
   modport sink (input valid, point_x, point_y, first_vertex, last_vertex, output ready);
endinterface

interface plc_rsp_if #(
   parameter int COORD_WIDTH = plc_pkg::COORD_WIDTH_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] out_x;
   logic [COORD_WIDTH-1:0] out_y;
   logic                   end_of_run;

   modport source (output valid, out_x, out_y, end_of_run, input ready);
   modport sink (input valid, out_x, out_y, end_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/plc_mul_serial.sv
`default_nettype none

module plc_mul_serial #(
   parameter int AW = 25,
   parameter int BW = 25
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [AW-1:0]    a,
   input  wire logic [BW-1:0]    b,
   output logic                  done,
   output logic [AW+BW-1:0]      product
);

   localparam int CNTW = (BW > 1) ? $clog2(BW) : 1;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]   a_ff, a_in;
   logic [AW-1:0]   acc_ff, acc_in;
   logic [BW-1:0]   lo_ff, lo_in;
   logic [AW:0]     sum;

   assign sum = {1'b0, acc_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      if (start) begin
         a_in    = a;
         acc_in  = '0;
         lo_in   = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum[AW:1];
         lo_in  = {sum[0], lo_ff[BW-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(BW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
   end

   assign done    = done_ff;
   assign product = {acc_ff, lo_ff};

endmodule

`default_nettype wire

>>> rtl/plc_sqrt_serial.sv
`default_nettype none

module plc_sqrt_serial #(
   parameter int RW = 25
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [2*RW-1:0] radicand,
   output logic                 done,
   output logic [RW-1:0]        root
);

   localparam int CNTW = (RW > 1) ? $clog2(RW) : 1;

   logic            busy_ff, busy_in;
   logic            round_ff, round_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [2*RW-1:0] rad_ff, rad_in;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [RW+3:0]   shifted;
   logic [RW+3:0]   trial;
   logic [RW+3:0]   diff;
   logic            fits;

   assign shifted = {rem_ff, rad_ff[2*RW-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign fits    = shifted >= trial;
   assign diff    = shifted - trial;

   always_comb begin
      busy_in  = busy_ff;
      round_in = 1'b0;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? (RW+2)'(diff) : (RW+2)'(shifted);
         root_in = {root_ff[RW-2:0], fits};
         rad_in  = rad_ff << 2;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(RW - 1)) begin
            busy_in  = 1'b0;
            round_in = 1'b1;
         end
      end else if (round_ff) begin
         if (rem_ff > (RW+2)'(root_ff)) begin
            root_in = root_ff + 1'b1;
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

>>> rtl/plc_div_serial.sv
`default_nettype none

module plc_div_serial #(
   parameter int QW = 25,
   parameter int NW = 50
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] numer,
   input  wire logic [QW-1:0] denom,
   output logic               done,
   output logic [QW-1:0]      quotient
);

   localparam int CNTW = (QW > 1) ? $clog2(QW) : 1;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [QW-1:0]   rem_ff, rem_in;
   logic [QW-1:0]   low_ff, low_in;
   logic [QW-1:0]   den_ff, den_in;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [QW:0]     shifted;
   logic            fits;

   assign shifted = {rem_ff, low_ff[QW-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         rem_in  = QW'(numer >> QW);
         low_in  = numer[QW-1:0];
         den_in  = denom;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? QW'(shifted - {1'b0, den_ff}) : QW'(shifted);
         low_in = low_ff << 1;
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/polyline_length_clipper_core.sv
// Polyline length clipper: takes vertices (signed Q12.12) one item at a time and passes the part
// of each polyline that lies within clip_length (register at byte address 0, reset 4.0) of its
// first vertex, emitting the point interpolated at exactly that length as the last item of the
// run and dropping further vertices until the next first vertex. One item is in work at a time.
// Every arithmetic step is bit serial. A first vertex goes from ST_DECIDE straight to ST_EMIT;
// a passed vertex runs the serial squaring, then the serial square root; the clipping vertex
// adds the serial scale multiply and the serial division, unless its segment has zero length,
// in which case the previous point is emitted. A dropped vertex returns from ST_DECIDE to
// ST_IDLE. A finished item waits in the output register, so the next vertex is accepted while
// it is still pending.
`default_nettype none

module polyline_length_clipper_core #(
   parameter int COORD_WIDTH = plc_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   plc_req_if.sink                                   req_port,
   plc_rsp_if.source                                 rsp_port,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [plc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [plc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [plc_pkg::CSR_DATA_WIDTH-1:0]        csr_prdata,
   output logic                                      csr_pready
);

   localparam int CW   = COORD_WIDTH;
   localparam int MW   = CW + 1;
   localparam int SQW  = 2 * MW;
   localparam int CLW  = plc_pkg::CLIP_WIDTH;
   localparam int LW   = plc_pkg::LEN_WIDTH;
   localparam int MAXW = (MW > CLW) ? MW : CLW;
   localparam int PW   = MW + MAXW;
   localparam int NW   = MW + CLW + 1;
   localparam int TW   = ((LW > MW) ? LW : MW) + 1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DECIDE = 8'b0000_0010,
      ST_SQUARE = 8'b0000_0100,
      ST_ROOT   = 8'b0000_1000,
      ST_CHECK  = 8'b0001_0000,
      ST_SCALE  = 8'b0010_0000,
      ST_DIVIDE = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  x_ff, x_in, y_ff, y_in;
   logic           first_ff, first_in, last_ff, last_in;
   logic [MW-1:0]  dmx_ff, dmx_in, dmy_ff, dmy_in;
   logic           dnx_ff, dnx_in, dny_ff, dny_in;
   logic [CW-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [LW-1:0]  len_ff, len_in;
   logic           done_ff, done_in;
   logic [CLW-1:0] clip_ff, clip_in;
   logic [MW-1:0]  seg_ff, seg_in;
   logic [CW-1:0]  res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic           res_end_ff, res_end_in;
   logic           out_valid_ff, out_valid_in;
   logic [CW-1:0]  out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic           out_end_ff, out_end_in;

   logic signed [CW:0] dx, dy;
   logic               csr_write;
   logic               mul_start, sqrt_start, div_start;
   logic [MAXW-1:0]    mul_bx, mul_by;
   logic [PW-1:0]      prod_x, prod_y;
   logic               mul_x_done, mul_y_done;
   logic [SQW-1:0]     radicand;
   logic               sqrt_done;
   logic [MW-1:0]      sqrt_root;
   logic [NW-1:0]      numer_x, numer_y;
   logic [MW-1:0]      quo_x, quo_y;
   logic               div_x_done, div_y_done;
   logic [TW-1:0]      total;
   logic [CLW-1:0]     remain;
   logic [LW-1:0]      len_sat;
   logic [CW-1:0]      ix, iy;

   function automatic logic [CW-1:0] interp(input logic [CW-1:0] p, input logic neg,
                                            input logic [MW-1:0] q);
      logic signed [CW+1:0] ps;
      logic signed [CW+1:0] qs;
      logic signed [CW+1:0] r;
      ps = (CW+2)'($signed(p));
      qs = $signed({1'b0, q});
      r  = neg ? ps - qs : ps + qs;
      return r[CW-1:0];
   endfunction

   assign dx = $signed({req_port.point_x[CW-1], req_port.point_x})
             - $signed({prev_x_ff[CW-1], prev_x_ff});
   assign dy = $signed({req_port.point_y[CW-1], req_port.point_y})
             - $signed({prev_y_ff[CW-1], prev_y_ff});

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[plc_pkg::CSR_INDEX_BIT] == plc_pkg::REG_CLIP_LENGTH)
                     ? plc_pkg::CSR_DATA_WIDTH'(clip_ff) : '0;

   assign total   = TW'(len_ff) + TW'(seg_ff);
   assign remain  = (len_ff < LW'(clip_ff)) ? CLW'(LW'(clip_ff) - len_ff) : '0;
   assign len_sat = (total > TW'(plc_pkg::LEN_MAX)) ? plc_pkg::LEN_MAX : LW'(total);

   assign mul_bx   = (state_ff == ST_CHECK) ? MAXW'(remain) : MAXW'(dmx_ff);
   assign mul_by   = (state_ff == ST_CHECK) ? MAXW'(remain) : MAXW'(dmy_ff);
   assign radicand = SQW'(prod_x) + SQW'(prod_y);
   assign numer_x  = NW'(prod_x) + NW'(seg_ff >> 1);
   assign numer_y  = NW'(prod_y) + NW'(seg_ff >> 1);
   assign ix       = interp(prev_x_ff, dnx_ff, quo_x);
   assign iy       = interp(prev_y_ff, dny_ff, quo_y);

   plc_mul_serial #(.AW(MW), .BW(MAXW)) u_mul_x (
      .clock(clock), .reset(reset), .start(mul_start), .a(dmx_ff), .b(mul_bx),
      .done(mul_x_done), .product(prod_x)
   );

   plc_mul_serial #(.AW(MW), .BW(MAXW)) u_mul_y (
      .clock(clock), .reset(reset), .start(mul_start), .a(dmy_ff), .b(mul_by),
      .done(mul_y_done), .product(prod_y)
   );

   plc_sqrt_serial #(.RW(MW)) u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .radicand(radicand),
      .done(sqrt_done), .root(sqrt_root)
   );

   plc_div_serial #(.QW(MW), .NW(NW)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start), .numer(numer_x), .denom(seg_ff),
      .done(div_x_done), .quotient(quo_x)
   );

   plc_div_serial #(.QW(MW), .NW(NW)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start), .numer(numer_y), .denom(seg_ff),
      .done(div_y_done), .quotient(quo_y)
   );

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      dmx_in       = dmx_ff;
      dmy_in       = dmy_ff;
      dnx_in       = dnx_ff;
      dny_in       = dny_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      len_in       = len_ff;
      done_in      = done_ff;
      clip_in      = clip_ff;
      seg_in       = seg_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_end_in   = res_end_ff;
      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_end_in   = out_end_ff;
      mul_start    = 1'b0;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;

      if (csr_write && csr_paddr[plc_pkg::CSR_INDEX_BIT] == plc_pkg::REG_CLIP_LENGTH) begin
         clip_in = csr_pwdata[CLW-1:0];
      end
      if (out_valid_ff && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               x_in     = req_port.point_x;
               y_in     = req_port.point_y;
               first_in = req_port.first_vertex;
               last_in  = req_port.last_vertex;
               dnx_in   = dx[CW];
               dny_in   = dy[CW];
               dmx_in   = dx[CW] ? MW'(-dx) : MW'(dx);
               dmy_in   = dy[CW] ? MW'(-dy) : MW'(dy);
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (first_ff) begin
               prev_x_in  = x_ff;
               prev_y_in  = y_ff;
               len_in     = '0;
               done_in    = last_ff || (clip_ff == '0);
               res_x_in   = x_ff;
               res_y_in   = y_ff;
               res_end_in = last_ff || (clip_ff == '0);
               state_in   = ST_EMIT;
            end else if (done_ff) begin
               state_in = ST_IDLE;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (mul_x_done) begin
               sqrt_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               seg_in   = sqrt_root;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (total < TW'(clip_ff)) begin
               len_in     = LW'(total);
               prev_x_in  = x_ff;
               prev_y_in  = y_ff;
               done_in    = last_ff;
               res_x_in   = x_ff;
               res_y_in   = y_ff;
               res_end_in = last_ff;
               state_in   = ST_EMIT;
            end else begin
               len_in     = len_sat;
               done_in    = 1'b1;
               res_end_in = 1'b1;
               if (seg_ff == '0) begin
                  res_x_in = prev_x_ff;
                  res_y_in = prev_y_ff;
                  state_in = ST_EMIT;
               end else begin
                  mul_start = 1'b1;
                  state_in  = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            if (mul_x_done) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_x_done) begin
               res_x_in  = ix;
               res_y_in  = iy;
               prev_x_in = ix;
               prev_y_in = iy;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_port.ready) begin
               out_valid_in = 1'b1;
               out_x_in     = res_x_ff;
               out_y_in     = res_y_ff;
               out_end_in   = res_end_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clip_ff      <= plc_pkg::CLIP_RESET;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         len_ff       <= '0;
         done_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clip_ff      <= clip_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         len_ff       <= len_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      first_ff   <= first_in;
      last_ff    <= last_in;
      dmx_ff     <= dmx_in;
      dmy_ff     <= dmy_in;
      dnx_ff     <= dnx_in;
      dny_ff     <= dny_in;
      seg_ff     <= seg_in;
      res_x_ff   <= res_x_in;
      res_y_ff   <= res_y_in;
      res_end_ff <= res_end_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_end_ff <= out_end_in;
   end

   assign req_port.ready      = (state_ff == ST_IDLE);
   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.out_x      = out_x_ff;
   assign rsp_port.out_y      = out_y_ff;
   assign rsp_port.end_of_run = out_end_ff;

   a_one_item_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("item accepted while another is in work");

   a_mul_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      mul_x_done == mul_y_done)
      else $error("multiplier lanes out of step");

   a_div_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      div_x_done == div_y_done)
      else $error("divider lanes out of step");

   a_scale_nonzero_seg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE || state_ff == ST_DIVIDE) |-> (seg_ff != '0))
      else $error("interpolation started on a zero-length segment");

endmodule

`default_nettype wire
